### rtl/cdq_pkg.sv
`default_nettype none
package cdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // decoded item as held in the queue between front and back end
  typedef struct packed {
    logic                      push;
    logic                      pop;
    logic                      at_front;
    logic signed [VALUE_W-1:0] value;
  } cdq_cmd_t;

endpackage
`default_nettype wire

### rtl/cdq_ram.sv
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### rtl/cdq_front.sv
`default_nettype none
module cdq_front
  import cdq_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [FUNC_W-1:0]         in_func,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           cmd_valid,
  output cdq_cmd_t                       cmd,
  input  wire logic                      cmd_pop
);

  cdq_cmd_t   q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       accept;
  cdq_cmd_t   dec;

  // unused codes fall through as query
  always_comb begin
    dec          = '0;
    dec.value    = in_value;
    case (in_func)
      FN_PUSH_FRONT: begin
        dec.push     = 1'b1;
        dec.at_front = 1'b1;
      end
      FN_PUSH_BACK: begin
        dec.push     = 1'b1;
      end
      FN_POP_FRONT: begin
        dec.pop      = 1'b1;
        dec.at_front = 1'b1;
      end
      FN_POP_BACK: begin
        dec.pop      = 1'b1;
      end
      default: begin
        dec.push     = 1'b0;
      end
    endcase
  end

  assign busy      = (fill_r == 2'd2);
  assign accept    = start && !busy;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, accept} - {1'b0, cmd_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule
`default_nettype wire

### rtl/cdq_back.sv
`default_nettype none
module cdq_back
  import cdq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cmd_valid,
  input  wire cdq_cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_front_value,
  output logic signed [VALUE_W-1:0] out_back_value,
  output logic [COUNT_W-1:0]        out_count,
  output logic                      out_is_empty,
  output logic                      out_is_full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 we;
  logic [PTR_W-1:0]     waddr;
  logic [VALUE_W-1:0]   rd_front, rd_back;
  logic [EXT_W-1:0]     cnt_ext;
  logic                 empty, full;
  logic [PTR_W-1:0]     head_inc, head_dec, tail_inc, tail_dec;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_FULL);
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? PTR_LAST : head_r - 1'b1;
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? PTR_LAST : tail_r - 1'b1;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = '0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt  = S_READ;
          status_nxt = ST_DONE;
          if (cmd.push) begin
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              we      = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              if (empty) begin
                head_nxt = '0;
                tail_nxt = '0;
                waddr    = '0;
              end else if (cmd.at_front) begin
                head_nxt = head_dec;
                waddr    = head_dec;
              end else begin
                tail_nxt = tail_inc;
                waddr    = tail_inc;
              end
            end
          end else if (cmd.pop) begin
            if (empty) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              cnt_nxt = cnt_r - 1'b1;
              if (cnt_r == CNT_W'(1)) begin
                head_nxt = '0;
                tail_nxt = '0;
              end else if (cmd.at_front) begin
                head_nxt = head_inc;
              end else begin
                tail_nxt = tail_dec;
              end
            end
          end
        end
      end
      S_READ:  state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      cnt_r    <= '0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
    end
  end

  cdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (cmd.value),
    .raddr_a (head_r),
    .raddr_b (tail_r),
    .rdata_a (rd_front),
    .rdata_b (rd_back)
  );

  assign cnt_ext         = EXT_W'(cnt_r);
  assign out_valid       = (state_r == S_RESP);
  assign out_status      = status_r;
  assign out_count       = cnt_ext[COUNT_W-1:0];
  assign out_is_empty    = empty;
  assign out_is_full     = full;
  assign out_front_value = empty ? '1 : rd_front;
  assign out_back_value  = empty ? '1 : rd_back;

endmodule
`default_nettype wire

### rtl/circular_deque_core.sv
`default_nettype none
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// words. An item is taken when start is high and busy is low; up to two
// items wait in an input queue, and busy rises while both places are taken.
// The back end takes each item through S_IDLE, S_READ and S_RESP: update
// pointers and write the store, read the front and back words from the
// store's registered port, then present the result. Each result is shown
// for exactly one cycle with out_valid high and cannot be held off, so the
// receiver must take it then. The back end takes a new item only after the
// last result. Front and back values read -1 when the deque is empty.
module circular_deque_core
  import cdq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [FUNC_W-1:0]         in_func,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                           out_valid,
  output logic [STATUS_W-1:0]            out_status,
  output logic signed [VALUE_W-1:0]      out_front_value,
  output logic signed [VALUE_W-1:0]      out_back_value,
  output logic [COUNT_W-1:0]             out_count,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  logic     cmd_valid;
  logic     cmd_pop;
  cdq_cmd_t cmd;

  cdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_func   (in_func),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule
`default_nettype wire

### rtl/cdq_checker.sv
`default_nettype none
module cdq_checker
  import cdq_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic [STATUS_W-1:0]       out_status,
  input wire logic signed [VALUE_W-1:0] out_front_value,
  input wire logic signed [VALUE_W-1:0] out_back_value,
  input wire logic [COUNT_W-1:0]        out_count,
  input wire logic                      out_is_empty,
  input wire logic                      out_is_full
);

  a_strobe_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in adjacent cycles");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
      out_count == '0 && out_front_value == -32'sd1 && out_back_value == -32'sd1)
    else $error("empty result with count or values set");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_full && out_is_empty))
    else $error("full and empty together");

  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_is_empty)
    else $error("underflow on non-empty deque");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_is_full)
    else $error("overflow on non-full deque");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_front_value (out_front_value),
  .out_back_value  (out_back_value),
  .out_count       (out_count),
  .out_is_empty    (out_is_empty),
  .out_is_full     (out_is_full)
);
`default_nettype wire

### bench/circular_deque_checker.sv
`timescale 1ns / 1ps

module circular_deque_checker
  import cdq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic signed [VALUE_W-1:0] out_front_value,
  input  logic signed [VALUE_W-1:0] out_back_value,
  input  logic [COUNT_W-1:0]        out_count,
  input  logic                      out_is_empty,
  input  logic                      out_is_full,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic                      is_full;
  } deque_view_t;

  deque_view_t               expected_views[$];
  logic signed [VALUE_W-1:0] store [DEPTH];
  int                        head_at;
  int                        tail_at;
  int                        held;

  initial begin
    fail_count = 0;
    pending    = 0;
    head_at    = 0;
    tail_at    = 0;
    held       = 0;
  end

  function automatic deque_view_t apply_op(input logic [FUNC_W-1:0] f,
                                           input logic signed [VALUE_W-1:0] v);
    deque_view_t r;
    r.status = ST_DONE;
    case (f)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (held == 0) begin
            head_at = 0;
            tail_at = 0;
          end else if (f == FN_PUSH_FRONT) begin
            head_at = (head_at == 0) ? DEPTH - 1 : head_at - 1;
          end else begin
            tail_at = (tail_at == DEPTH - 1) ? 0 : tail_at + 1;
          end
          store[(f == FN_PUSH_FRONT) ? head_at : tail_at] = v;
          held++;
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (held == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          if (held == 1) begin
            head_at = 0;
            tail_at = 0;
          end else if (f == FN_POP_FRONT) begin
            head_at = (head_at == DEPTH - 1) ? 0 : head_at + 1;
          end else begin
            tail_at = (tail_at == 0) ? DEPTH - 1 : tail_at - 1;
          end
          held--;
        end
      end
      default: ;  // query and unused codes
    endcase
    r.is_empty    = (held == 0);
    r.is_full     = (held == DEPTH);
    r.count       = COUNT_W'(held);
    r.front_value = r.is_empty ? '1 : store[head_at];
    r.back_value  = r.is_empty ? '1 : store[tail_at];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                             input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deque_view_t want;
    if (!rst_n) begin
      expected_views.delete();
      head_at = 0;
      tail_at = 0;
      held    = 0;
    end else begin
      if (out_valid) begin
        if (expected_views.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          want = expected_views[0];
          expected_views.delete(0);
          check_field("status", VALUE_W'(want.status), VALUE_W'(out_status));
          check_field("front_value", want.front_value, out_front_value);
          check_field("back_value", want.back_value, out_back_value);
          check_field("count", VALUE_W'(want.count), VALUE_W'(out_count));
          check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(out_is_empty));
          check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(out_is_full));
        end
      end
      if (start && !busy)
        expected_views.insert(expected_views.size(), apply_op(in_func, in_value));
    end
    pending = expected_views.size();
  end

endmodule

### bench/circular_deque_core_tb.sv
`timescale 1ns / 1ps

module circular_deque_core_tb;
  import cdq_pkg::*;

  localparam int DEPTH = 128;
  localparam logic [FUNC_W-1:0] FN_QUERY  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 400;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [FUNC_W-1:0]         in_func;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_front_value;
  logic signed [VALUE_W-1:0] out_back_value;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_is_empty;
  logic                      out_is_full;
  int                        fail_count;
  int                        pending;
  int                        occupancy;
  int                        random_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_deque_core #(.DEPTH(DEPTH)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_front_value(out_front_value), .out_back_value(out_back_value),
    .out_count(out_count), .out_is_empty(out_is_empty), .out_is_full(out_is_full)
  );

  circular_deque_checker #(.DEPTH(DEPTH)) i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_front_value(out_front_value), .out_back_value(out_back_value),
    .out_count(out_count), .out_is_empty(out_is_empty), .out_is_full(out_is_full),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic [FUNC_W-1:0] f,
                           input logic signed [VALUE_W-1:0] v, input bit quiet);
    int gap;
    start    <= 1'b1;
    in_func  <= f;
    in_value <= v;
    do @(posedge clk); while (busy);
    if ((f == FN_PUSH_FRONT || f == FN_PUSH_BACK) && occupancy < DEPTH)
      occupancy++;
    else if ((f == FN_POP_FRONT || f == FN_POP_BACK) && occupancy > 0)
      occupancy--;
    @(negedge clk);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      start    <= 1'b0;
      in_func  <= FUNC_W'($urandom());
      in_value <= $urandom();
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random(input int push_weight, input bit quiet);
    int                        r;
    logic [FUNC_W-1:0]         f;
    logic signed [VALUE_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < push_weight)
      f = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
    else if (r < 97)
      f = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
    else
      f = FUNC_W'($urandom_range(FN_QUERY, FN_SPARE7));
    case ($urandom_range(0, 9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = '1;
      default: v = $urandom();
    endcase
    send_item(f, v, quiet);
    random_sent++;
  endtask

  initial begin
    traffic_mode_t mode;
    bit            quiet;
    int            n;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = FN_PUSH_FRONT;
    in_value    = '0;
    occupancy   = 0;
    random_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(FN_POP_FRONT, 32'h1234_5678, 1'b0);
    send_item(FN_POP_BACK, '1, 1'b0);
    send_item(FN_QUERY, 32'h0000_0001, 1'b0);
    send_item(FN_SPARE5, 32'h8000_0000, 1'b0);
    send_item(FN_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    send_item(FN_POP_FRONT, '0, 1'b0);
    send_item(FN_PUSH_BACK, 32'h8000_0000, 1'b1);
    send_item(FN_PUSH_FRONT, 32'h0000_0000, 1'b1);
    send_item(FN_PUSH_BACK, 32'hffff_ffff, 1'b1);
    send_item(FN_PUSH_FRONT, 32'h5555_5555, 1'b0);
    send_item(FN_PUSH_BACK, 32'haaaa_aaaa, 1'b0);
    send_item(FN_SPARE6, $urandom(), 1'b0);
    send_item(FN_SPARE7, $urandom(), 1'b0);
    send_item(FN_POP_BACK, $urandom(), 1'b0);
    send_item(FN_POP_FRONT, $urandom(), 1'b1);
    send_item(FN_POP_BACK, $urandom(), 1'b1);
    send_item(FN_POP_FRONT, $urandom(), 1'b0);
    send_item(FN_POP_BACK, $urandom(), 1'b0);
    send_item(FN_POP_FRONT, $urandom(), 1'b0);
    send_item(FN_QUERY, $urandom(), 1'b0);

    mode = MODE_FILL;
    while (random_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case (mode)
        MODE_FILL: begin
          while (occupancy < DEPTH && random_sent < RANDOM_ITEMS)
            send_random(80, quiet);
          repeat (4) send_random(90, quiet);  // refused pushes
          mode = MODE_MIX;
        end
        MODE_DRAIN: begin
          while (occupancy > 0 && random_sent < RANDOM_ITEMS)
            send_random(15, quiet);
          repeat (4) send_random(5, quiet);   // refused pops
          mode = MODE_MIX;
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) send_random(50, quiet);
          mode = (occupancy > DEPTH / 2) ? MODE_DRAIN : MODE_FILL;
        end
      endcase
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
